### rtl/psu_pkg.sv
package psu_pkg;

   localparam int PIXEL_BITS = 8;
   localparam int COUNT_BITS_DEF = 24;
   localparam int FRAC_BITS = 8;
   localparam int MEAN_QBITS = 16;
   localparam int MSQ_QBITS = 24;
   localparam int VAR_QBITS = 30;
   localparam int STD_BITS = 15;
   localparam int PCOUNT_BITS = 25;
   localparam int ROOT_STEPS = VAR_QBITS / 2;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_end;
   } req_word_type;

   typedef struct packed {
      logic [15:0]            mean;
      logic [23:0]            mean_square;
      logic [STD_BITS-1:0]    std_dev;
      logic [7:0]             min_value;
      logic [7:0]             max_value;
      logic [PCOUNT_BITS-1:0] pixel_count;
      logic                   empty_res;
   } rsp_word_type;

   typedef enum logic [1:0] {
      MUL_N_N     = 2'd0,
      MUL_N_SUMSQ = 2'd1,
      MUL_SUM_SUM = 2'd2
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_MEAN = 2'd0,
      DIV_MSQ  = 2'd1,
      DIV_VAR  = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        accept;
      logic        snap;
      logic        mul_load;
      mul_sel_type mul_sel;
      logic        mul_step;
      logic        keep_n2;
      logic        keep_a;
      logic        div_load;
      div_sel_type div_sel;
      logic        div_step;
      logic        keep_mean;
      logic        keep_msq;
      logic        sqrt_load;
      logic        sqrt_step;
      logic        out_load;
   } psu_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic out_free;
   } psu_status_type;

endpackage

### rtl/psu_ctrl.sv
module psu_ctrl
   import psu_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_frame_end,
   output logic           req_stall,
   input  psu_status_type status,
   output psu_cmd_type    cmd
);

   localparam int N_W = COUNT_BITS + 1;
   localparam int SUM_W = PIXEL_BITS + COUNT_BITS;
   localparam int MAX_STEPS = (SUM_W > VAR_QBITS) ? SUM_W : VAR_QBITS;
   localparam int CNT_W = $clog2(MAX_STEPS);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_START = 11'b00000000010,
      S_DIVM  = 11'b00000000100,
      S_DIVQ  = 11'b00000001000,
      S_MULN  = 11'b00000010000,
      S_MULA  = 11'b00000100000,
      S_MULB  = 11'b00001000000,
      S_DIFF  = 11'b00010000000,
      S_DIVV  = 11'b00100000000,
      S_ROOT  = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last;
   logic             accept;

   // Only a frame-closing word has to wait for the previous frame's results.
   assign req_stall = (state_ff != S_IDLE) && req_frame_end;
   assign accept = req_valid && !req_stall;
   assign last = (cnt_ff == '0);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff - CNT_W'(1);
      cmd = '0;
      cmd.mul_sel = MUL_N_N;
      cmd.div_sel = DIV_MEAN;
      cmd.accept = accept;
      cmd.snap = accept && req_frame_end;
      case (state_ff)
         S_IDLE: begin
            if (cmd.snap) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (status.n_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.div_load = 1'b1;
               cmd.div_sel = DIV_MEAN;
               cnt_in = CNT_W'(MEAN_QBITS - 1);
               state_in = S_DIVM;
            end
         end
         S_DIVM: begin
            cmd.div_step = 1'b1;
            if (last) begin
               cmd.keep_mean = 1'b1;
               cmd.div_load = 1'b1;
               cmd.div_sel = DIV_MSQ;
               cnt_in = CNT_W'(MSQ_QBITS - 1);
               state_in = S_DIVQ;
            end
         end
         S_DIVQ: begin
            cmd.div_step = 1'b1;
            if (last) begin
               cmd.keep_msq = 1'b1;
               cmd.mul_load = 1'b1;
               cmd.mul_sel = MUL_N_N;
               cnt_in = CNT_W'(N_W - 1);
               state_in = S_MULN;
            end
         end
         S_MULN: begin
            cmd.mul_step = 1'b1;
            if (last) begin
               cmd.keep_n2 = 1'b1;
               cmd.mul_load = 1'b1;
               cmd.mul_sel = MUL_N_SUMSQ;
               cnt_in = CNT_W'(N_W - 1);
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            cmd.mul_step = 1'b1;
            if (last) begin
               cmd.keep_a = 1'b1;
               cmd.mul_load = 1'b1;
               cmd.mul_sel = MUL_SUM_SUM;
               cnt_in = CNT_W'(SUM_W - 1);
               state_in = S_MULB;
            end
         end
         S_MULB: begin
            cmd.mul_step = 1'b1;
            if (last) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.div_load = 1'b1;
            cmd.div_sel = DIV_VAR;
            cnt_in = CNT_W'(VAR_QBITS - 1);
            state_in = S_DIVV;
         end
         S_DIVV: begin
            cmd.div_step = 1'b1;
            if (last) begin
               cmd.sqrt_load = 1'b1;
               cnt_in = CNT_W'(ROOT_STEPS - 1);
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd.sqrt_step = 1'b1;
            if (last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/psu_datapath.sv
module psu_datapath
   import psu_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  req_word_type   req_data,
   input  logic           csr_wr_en,
   input  logic           csr_wr_data,
   input  psu_cmd_type    cmd,
   output psu_status_type status,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output rsp_word_type   rsp_data
);

   localparam int N_W = COUNT_BITS + 1;
   localparam int SUM_W = PIXEL_BITS + COUNT_BITS;
   localparam int SQ_W = 2 * PIXEL_BITS + COUNT_BITS;
   localparam int PR_W = 2 * PIXEL_BITS + 2 * COUNT_BITS;
   localparam int DV_W = 2 * COUNT_BITS + 1;
   localparam int DD_W = PR_W + 2 * FRAC_BITS;
   localparam int VQ = VAR_QBITS;
   localparam int MP_W = SUM_W;

   // Frame accumulators.
   logic                    skip_ff;
   logic [SUM_W-1:0]        sum_ff, sum_in, sum_upd;
   logic [SQ_W-1:0]         sumsq_ff, sumsq_in, sumsq_upd;
   logic [N_W-1:0]          count_ff, count_in, count_upd;
   logic [PIXEL_BITS-1:0]   min_ff, min_in, min_upd;
   logic [PIXEL_BITS-1:0]   max_ff, max_in, max_upd;
   logic [PIXEL_BITS-1:0]   pix;
   logic [2*PIXEL_BITS-1:0] pix_sq;
   logic                    counted;

   // Closed frame.
   logic [SUM_W-1:0]        snap_sum_ff;
   logic [SQ_W-1:0]         snap_sumsq_ff;
   logic [N_W-1:0]          snap_n_ff;
   logic [PIXEL_BITS-1:0]   snap_min_ff;
   logic [PIXEL_BITS-1:0]   snap_max_ff;

   // Shift-add multiplier.
   logic [PR_W-1:0]         prod_ff, prod_step;
   logic [PR_W-1:0]         mcand_ff;
   logic [MP_W-1:0]         mplier_ff;
   logic [PR_W-1:0]         a_ff;
   logic [DV_W-1:0]         n2_ff;

   // Restoring divider.
   logic [DV_W-1:0]         rem_ff, rem_step, rem_init;
   logic [DV_W-1:0]         dsor_ff, dsor_init;
   logic [VQ-1:0]           lo_ff, lo_init;
   logic [VQ-1:0]           quot_ff, quot_step;
   logic [DV_W:0]           trial;
   logic                    trial_ge;
   logic [DD_W-1:0]         dividend;
   logic [PR_W-1:0]         diff;

   // Digit-by-digit square root.
   logic [VQ-1:0]           v_ff, v_step;
   logic [VQ-1:0]           root_ff, root_step;
   logic [VQ-1:0]           bit_ff;
   logic [VQ:0]             root_bit;
   logic                    root_ge;

   logic [15:0]             mean_ff;
   logic [23:0]             msq_ff;

   logic                    rsp_valid_ff;
   rsp_word_type            rsp_data_ff;

   assign pix = req_data.pixel;
   assign pix_sq = (2 * PIXEL_BITS)'(pix) * (2 * PIXEL_BITS)'(pix);
   // Once the count saturates the rest of the frame is ignored.
   assign counted = cmd.accept && !(skip_ff && (pix == '0)) && !count_ff[COUNT_BITS];

   always_comb begin
      sum_upd = sum_ff;
      sumsq_upd = sumsq_ff;
      count_upd = count_ff;
      min_upd = min_ff;
      max_upd = max_ff;
      if (counted) begin
         sum_upd = sum_ff + SUM_W'(pix);
         sumsq_upd = sumsq_ff + SQ_W'(pix_sq);
         count_upd = count_ff + N_W'(1);
         if (pix < min_ff) begin
            min_upd = pix;
         end
         if (pix > max_ff) begin
            max_upd = pix;
         end
      end
      if (cmd.snap) begin
         sum_in = '0;
         sumsq_in = '0;
         count_in = '0;
         min_in = '1;
         max_in = '0;
      end else begin
         sum_in = sum_upd;
         sumsq_in = sumsq_upd;
         count_in = count_upd;
         min_in = min_upd;
         max_in = max_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b0;
         sum_ff <= '0;
         sumsq_ff <= '0;
         count_ff <= '0;
         min_ff <= '1;
         max_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            skip_ff <= csr_wr_data;
         end
         sum_ff <= sum_in;
         sumsq_ff <= sumsq_in;
         count_ff <= count_in;
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         snap_sum_ff <= sum_upd;
         snap_sumsq_ff <= sumsq_upd;
         snap_n_ff <= count_upd;
         snap_min_ff <= min_upd;
         snap_max_ff <= max_upd;
      end
   end

   assign status.n_zero = (snap_n_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Multiplier: one multiplier bit per cycle, LSB first.
   assign prod_step = prod_ff + (mplier_ff[0] ? mcand_ff : '0);

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         prod_ff <= '0;
         case (cmd.mul_sel)
            MUL_N_N: begin
               mcand_ff <= PR_W'(snap_n_ff);
               mplier_ff <= MP_W'(snap_n_ff);
            end
            MUL_N_SUMSQ: begin
               mcand_ff <= PR_W'(snap_sumsq_ff);
               mplier_ff <= MP_W'(snap_n_ff);
            end
            MUL_SUM_SUM: begin
               mcand_ff <= PR_W'(snap_sum_ff);
               mplier_ff <= MP_W'(snap_sum_ff);
            end
            default: begin
               mcand_ff <= '0;
               mplier_ff <= '0;
            end
         endcase
      end else if (cmd.mul_step) begin
         prod_ff <= prod_step;
         mcand_ff <= {mcand_ff[PR_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[MP_W-1:1]};
      end
      if (cmd.keep_n2) begin
         n2_ff <= DV_W'(prod_step);
      end
      if (cmd.keep_a) begin
         a_ff <= prod_step;
      end
   end

   // A non-positive variance gives a zero deviation.
   assign diff = (a_ff > prod_ff) ? (a_ff - prod_ff) : '0;

   // The quotient bound is known per operation, so the remainder starts out
   // with the dividend bits above the quotient and only the quotient bits are iterated.
   always_comb begin
      dividend = '0;
      rem_init = '0;
      lo_init = '0;
      dsor_init = '0;
      case (cmd.div_sel)
         DIV_MEAN: begin
            dividend = DD_W'(snap_sum_ff) << FRAC_BITS;
            rem_init = DV_W'(dividend >> MEAN_QBITS);
            lo_init = VQ'(dividend[MEAN_QBITS-1:0]) << (VQ - MEAN_QBITS);
            dsor_init = DV_W'(snap_n_ff);
         end
         DIV_MSQ: begin
            dividend = DD_W'(snap_sumsq_ff) << FRAC_BITS;
            rem_init = DV_W'(dividend >> MSQ_QBITS);
            lo_init = VQ'(dividend[MSQ_QBITS-1:0]) << (VQ - MSQ_QBITS);
            dsor_init = DV_W'(snap_n_ff);
         end
         DIV_VAR: begin
            dividend = DD_W'(diff) << (2 * FRAC_BITS);
            rem_init = DV_W'(dividend >> VQ);
            lo_init = dividend[VQ-1:0];
            dsor_init = n2_ff;
         end
         default: begin
            dividend = '0;
         end
      endcase
   end

   assign trial = {rem_ff, lo_ff[VQ-1]};
   assign trial_ge = (trial >= {1'b0, dsor_ff});
   assign rem_step = trial_ge ? DV_W'(trial - {1'b0, dsor_ff}) : DV_W'(trial);
   assign quot_step = {quot_ff[VQ-2:0], trial_ge};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= rem_init;
         lo_ff <= lo_init;
         dsor_ff <= dsor_init;
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_step;
         lo_ff <= {lo_ff[VQ-2:0], 1'b0};
         quot_ff <= quot_step;
      end
      if (cmd.keep_mean) begin
         mean_ff <= quot_step[MEAN_QBITS-1:0];
      end
      if (cmd.keep_msq) begin
         msq_ff <= quot_step[MSQ_QBITS-1:0];
      end
   end

   assign root_bit = {1'b0, root_ff} + {1'b0, bit_ff};
   assign root_ge = ({1'b0, v_ff} >= root_bit);
   assign v_step = root_ge ? VQ'({1'b0, v_ff} - root_bit) : v_ff;
   assign root_step = root_ge ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         v_ff <= quot_step;
         root_ff <= '0;
         bit_ff <= VQ'(1) << (VQ - 2);
      end else if (cmd.sqrt_step) begin
         v_ff <= v_step;
         root_ff <= root_step;
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.mean <= status.n_zero ? '0 : mean_ff;
         rsp_data_ff.mean_square <= status.n_zero ? '0 : msq_ff;
         rsp_data_ff.std_dev <= status.n_zero ? '0 : root_ff[STD_BITS-1:0];
         rsp_data_ff.min_value <= 8'(snap_min_ff);
         rsp_data_ff.max_value <= 8'(snap_max_ff);
         rsp_data_ff.pixel_count <= PCOUNT_BITS'(snap_n_ff);
         rsp_data_ff.empty_res <= status.n_zero;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### rtl/pixel_intensity_statistics_unit.sv
// Throughput: one pixel word per cycle; accumulation of a frame never stalls.
// The result word is worked out once the frame_end word is taken, by the shared
// shift-add multiplier, the one-bit-per-cycle divider and the square root; an
// empty frame skips all three.
// A frame_end word is held off while the previous frame is still being finished.
// Synchronous active-high reset clears the accumulators, skip_zeros and the result valid flag.
module pixel_intensity_statistics_unit
   import psu_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   psu_cmd_type    cmd;
   psu_status_type status;

   psu_ctrl #(
      .COUNT_BITS(COUNT_BITS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_frame_end(req_data.frame_end),
      .req_stall(req_stall),
      .status(status),
      .cmd(cmd)
   );

   psu_datapath #(
      .COUNT_BITS(COUNT_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd(cmd),
      .status(status),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

endmodule

### test/pixel_intensity_statistics_unit_tb.sv
`timescale 1ns / 100ps

module pixel_intensity_statistics_unit_tb;
   import psu_pkg::*;

   // How long a frame takes to finish once its last word is in.
   localparam int FINISH_CYCLES = 3 * COUNT_BITS_DEF + 98;
   localparam int IDLE_LIMIT = 4000;
   localparam longint unsigned COUNT_CAP = 64'd1 << COUNT_BITS_DEF;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;
   logic         csr_wr_en;
   logic         csr_wr_data;

   // Running frame statistics, mirrored from what the block should hold.
   longint unsigned stat_sum;
   longint unsigned stat_sumsq;
   longint unsigned stat_count;
   logic [7:0]      stat_min;
   logic [7:0]      stat_max;
   logic            skip_zeros_cfg;
   rsp_word_type    expected_stats[$];

   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_run = 0;
   bit          gaps_on;
   bit          stalls_on;

   pixel_intensity_statistics_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic void clear_stats();
      stat_sum = 0;
      stat_sumsq = 0;
      stat_count = 0;
      stat_min = 8'hFF;
      stat_max = 8'h00;
   endfunction

   function automatic rsp_word_type close_frame();
      rsp_word_type    w;
      longint unsigned n;
      longint unsigned a;
      longint unsigned b;
      longint unsigned d;
      longint unsigned n2;
      longint unsigned var_q;
      n = stat_count;
      w = '0;
      w.min_value = stat_min;
      w.max_value = stat_max;
      w.pixel_count = n[PCOUNT_BITS-1:0];
      w.empty_res = (n == 0);
      if (n != 0) begin
         w.mean = 16'((stat_sum << 8) / n);
         w.mean_square = 24'((stat_sumsq << 8) / n);
         a = n * stat_sumsq;
         b = stat_sum * stat_sum;
         if (a > b) begin
            d = a - b;
            n2 = n * n;
            // Split so that the scaled variance never overflows 64 bits.
            var_q = ((d / n2) << 16) + (((d % n2) << 16) / n2);
            w.std_dev = STD_BITS'(root_floor(var_q));
         end
      end
      return w;
   endfunction

   function automatic void take_pixel(req_word_type w);
      longint unsigned p;
      p = w.pixel;
      if (!(skip_zeros_cfg && p == 0) && stat_count < COUNT_CAP) begin
         stat_sum += p;
         stat_sumsq += p * p;
         stat_count += 1;
         if (w.pixel < stat_min) begin
            stat_min = w.pixel;
         end
         if (w.pixel > stat_max) begin
            stat_max = w.pixel;
         end
      end
      if (w.frame_end) begin
         expected_stats.push_back(close_frame());
         clear_stats();
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic send_pixel(input logic [7:0] pixel, input logic last);
      int unsigned  gap;
      req_word_type w;
      gap = pick_gap();
      w.pixel = pixel;
      w.frame_end = last;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do begin
         @(posedge clock);
      end while (req_stall);
      take_pixel(w);
   endtask

   // Holds the sender until every closed frame has come back.
   task automatic wait_results();
      req_valid <= 1'b0;
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_skip(input logic value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      skip_zeros_cfg = value;
   endtask

   task automatic send_random_frame(output int unsigned length);
      int unsigned r;
      int unsigned zero_pct;
      logic [7:0]  pix;
      bit          all_zero;
      length = ($urandom_range(0, 14) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
      zero_pct = skip_zeros_cfg ? 35 : 10;
      all_zero = skip_zeros_cfg && ($urandom_range(0, 7) == 0);
      for (int i = 0; i < length; i++) begin
         r = $urandom_range(0, 99);
         if (all_zero || r < zero_pct) begin
            pix = 8'd0;
         end else if (r < zero_pct + 10) begin
            pix = 8'd255;
         end else begin
            pix = 8'($urandom_range(0, 255));
         end
         send_pixel(pix, i == length - 1);
      end
   endtask

   task automatic test_extreme_pixels();
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      write_skip(1'b0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b1);
      // Largest spread the pixel range allows.
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b1);
      for (int i = 0; i < 8; i++) begin
         send_pixel(8'd1 << i, i == 7);
      end
      send_pixel(8'h55, 1'b0);
      send_pixel(8'hAA, 1'b1);
      wait_results();
   endtask

   task automatic test_skip_zeros();
      write_skip(1'b1);
      // A lone zero leaves nothing counted, so the frame is empty.
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd7, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd200, 1'b1);
      // A skipped zero still closes the frame.
      send_pixel(8'd5, 1'b0);
      send_pixel(8'd0, 1'b1);
      wait_results();
      write_skip(1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd0, 1'b1);
      wait_results();
   endtask

   task automatic test_random_frames(input int unsigned items, input bit with_gaps,
                                     input bit with_stalls);
      int unsigned sent;
      int unsigned length;
      gaps_on = with_gaps;
      stalls_on = with_stalls;
      sent = 0;
      while (sent < items) begin
         send_random_frame(length);
         sent += length;
      end
      wait_results();
   endtask

   // Each frame_end word after the first arrives while the previous frame is still finishing.
   task automatic test_back_to_back_frames();
      gaps_on = 1'b0;
      stalls_on = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_pixel(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)), 1'b1);
      end
      wait_results();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      clear_stats();
      skip_zeros_cfg = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_pixels();
      test_skip_zeros();
      test_random_frames(240, 1'b1, 1'b1);
      write_skip(1'b1);
      test_random_frames(160, 1'b1, 1'b1);
      test_back_to_back_frames();
      write_skip(1'b0);
      test_random_frames(160, 1'b0, 1'b0);

      wait_results();
      repeat (FINISH_CYCLES + 30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Result side: stall runs, mostly short, now and then long.
   always @(posedge clock) begin
      if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_run <= $urandom_range(0, 6);
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stats.size() == 0) begin
            report_mismatch("result word with no frame waiting");
         end else begin
            want = expected_stats.pop_front();
            if (rsp_data.mean !== want.mean)
               report_mismatch($sformatf("mean %0d, want %0d", rsp_data.mean, want.mean));
            if (rsp_data.mean_square !== want.mean_square)
               report_mismatch($sformatf("mean_square %0d, want %0d",
                                         rsp_data.mean_square, want.mean_square));
            if (rsp_data.std_dev !== want.std_dev)
               report_mismatch($sformatf("std_dev %0d, want %0d",
                                         rsp_data.std_dev, want.std_dev));
            if (rsp_data.min_value !== want.min_value)
               report_mismatch($sformatf("min_value %0d, want %0d",
                                         rsp_data.min_value, want.min_value));
            if (rsp_data.max_value !== want.max_value)
               report_mismatch($sformatf("max_value %0d, want %0d",
                                         rsp_data.max_value, want.max_value));
            if (rsp_data.pixel_count !== want.pixel_count)
               report_mismatch($sformatf("pixel_count %0d, want %0d",
                                         rsp_data.pixel_count, want.pixel_count));
            if (rsp_data.empty_res !== want.empty_res)
               report_mismatch($sformatf("empty_res %0d, want %0d",
                                         rsp_data.empty_res, want.empty_res));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
